>>> rtl/dipc_pkg.sv
`default_nettype none

package dipc_pkg;

   // fixed field widths
   localparam int SIZE_W    = 21;
   localparam int BYTE_W    = 8;
   localparam int CHK_W     = 32;
   localparam int LANES     = 4;

   // packet header codes
   localparam logic [BYTE_W-1:0] HDR_FIRST = 8'h4C;
   localparam logic [BYTE_W-1:0] HDR_REST  = 8'h5C;

   // one result beat
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_header;
      logic              end_of_packet;
      logic              end_of_image;
      logic [CHK_W-1:0]  image_checksum;
      logic              size_error;
      logic              last_of_item;
   } dipc_result_type;

   // controller to datapath
   typedef struct packed {
      logic restart;
      logic cand_load;
      logic cand_step;
      logic pay_set;
      logic pay_clear;
      logic accept;
      logic pend_to_out;
   } dipc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic size_bad;
      logic cand_low;
      logic two_results;
   } dipc_sts_type;

endpackage

`default_nettype wire

>>> rtl/dipc_rem.sv
`default_nettype none

// Bit-serial remainder: one dividend bit per cycle, done pulses after the last bit.
module dipc_rem #(
   parameter int DIV_W = 10
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [dipc_pkg::SIZE_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]           divisor,
   output logic                            done,
   output logic                            zero
);
   import dipc_pkg::*;

   localparam int CNT_W = $clog2(SIZE_W);

   logic [SIZE_W-1:0] shift_ff, shift_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    trial;

   // one restoring step
   always_comb begin
      trial    = {rem_ff, shift_ff[SIZE_W-1]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = DIV_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = DIV_W'(trial);
         end
         shift_in = {shift_ff[SIZE_W-2:0], 1'b0};
         cnt_in   = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(SIZE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   assign done = done_ff;
   assign zero = (rem_ff == '0);

endmodule

`default_nettype wire

>>> rtl/dipc_ctrl.sv
`default_nettype none

// Payload-length search sequencer and output slot control.
module dipc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic                 rem_done,
   input  wire logic                 rem_zero,
   output logic                      rem_start,
   input  wire dipc_pkg::dipc_sts_type sts,
   output dipc_pkg::dipc_cmd_type    cmd
);
   import dipc_pkg::*;

   localparam logic [1:0] ST_CHECK = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_READY = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       pend_valid_ff, pend_valid_in;
   logic       ready;
   logic       rsp_take;

   assign ready    = (state_ff == ST_READY) && !pend_valid_ff &&
                     (!out_valid_ff || rsp_tready);
   assign rsp_take = out_valid_ff && rsp_tready;

   // search sequencing
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      rem_start     = 1'b0;
      cmd.restart   = csr_we;
      cmd.accept    = req_tvalid && ready;
      cmd.pend_to_out = rsp_take && pend_valid_ff;
      unique case (state_ff)
         ST_CHECK: begin
            if (sts.size_bad) begin
               cmd.pay_clear = 1'b1;
               state_in      = ST_READY;
            end else begin
               cmd.cand_load = 1'b1;
               rem_start     = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_done) begin
               if (rem_zero) begin
                  cmd.pay_set = 1'b1;
                  state_in    = ST_READY;
               end else if (sts.cand_low) begin
                  cmd.pay_clear = 1'b1;
                  state_in      = ST_READY;
               end else begin
                  cmd.cand_step = 1'b1;
                  rem_start     = 1'b1;
               end
            end
         end
         ST_READY: state_in = ST_READY;
         default:  state_in = ST_CHECK;
      endcase
      if (csr_we) begin
         state_in = ST_CHECK;
      end
   end

   // output slot and pending beat
   always_comb begin
      out_valid_in  = out_valid_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.accept) begin
         out_valid_in  = 1'b1;
         pend_valid_in = sts.two_results;
      end else if (rsp_take) begin
         out_valid_in  = pend_valid_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CHECK;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   assign req_tready = ready;
   assign rsp_tvalid = out_valid_ff;

endmodule

`default_nettype wire

>>> rtl/dipc_datapath.sv
`default_nettype none

// Counters, lane sums, payload length, size register and result beats.
module dipc_datapath #(
   parameter int PAYLOAD_ALIGN   = 16,
   parameter int MAX_PAYLOAD     = 1024,
   parameter int MAX_IMAGE_BYTES = 1048576,
   parameter int PAY_W           = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [dipc_pkg::SIZE_W-1:0] csr_wdata,
   input  wire logic [dipc_pkg::BYTE_W-1:0] data_byte,
   input  wire dipc_pkg::dipc_cmd_type      cmd,
   output dipc_pkg::dipc_sts_type           sts,
   output logic [dipc_pkg::SIZE_W-1:0]      image_size,
   output logic [PAY_W-1:0]                 cand,
   output dipc_pkg::dipc_result_type        result
);
   import dipc_pkg::*;

   localparam int CAND_TOP = ((MAX_PAYLOAD - 1) / PAYLOAD_ALIGN) * PAYLOAD_ALIGN;

   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] img_cnt_ff, img_cnt_in;
   logic [PAY_W-1:0]  pkt_cnt_ff, pkt_cnt_in;
   logic [PAY_W-1:0]  pay_ff;
   logic [PAY_W-1:0]  cand_ff;
   logic              first_ff, first_in;
   logic [BYTE_W-1:0] lane_ff [LANES];
   logic [BYTE_W-1:0] lane_nx [LANES];
   logic [BYTE_W-1:0] lane_in [LANES];
   dipc_result_type   out_ff, pend_ff;
   dipc_result_type   hdr_res, data_res, err_res;
   logic              err, hdr, eop, eoi;
   logic [CHK_W-1:0]  checksum;

   // lane sums after this byte
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (img_cnt_ff[1:0] == 2'(i)) begin
            lane_nx[i] = BYTE_W'(lane_ff[i] + data_byte);
         end else begin
            lane_nx[i] = lane_ff[i];
         end
      end
      checksum = {lane_nx[0], lane_nx[1], lane_nx[2], lane_nx[3]};
   end

   assign err = (pay_ff == '0);
   assign hdr = (pkt_cnt_ff == '0);
   assign eop = ({1'b0, pkt_cnt_ff} + 1'b1) >= {1'b0, pay_ff};
   assign eoi = ({1'b0, img_cnt_ff} + 1'b1) >= {1'b0, size_ff};

   // candidate result beats
   always_comb begin
      hdr_res           = '0;
      hdr_res.out_byte  = first_ff ? HDR_FIRST : HDR_REST;
      hdr_res.is_header = 1'b1;

      data_res               = '0;
      data_res.out_byte      = data_byte;
      data_res.end_of_packet = eop || eoi;
      data_res.end_of_image  = eoi;
      data_res.image_checksum = eoi ? checksum : '0;
      data_res.last_of_item  = 1'b1;

      err_res              = '0;
      err_res.size_error   = 1'b1;
      err_res.last_of_item = 1'b1;
   end

   // image state update
   always_comb begin
      img_cnt_in = img_cnt_ff;
      pkt_cnt_in = pkt_cnt_ff;
      first_in   = first_ff;
      lane_in    = lane_ff;
      if (cmd.restart || (cmd.accept && !err && eoi)) begin
         img_cnt_in = '0;
         pkt_cnt_in = '0;
         first_in   = 1'b1;
         for (int i = 0; i < LANES; i++) begin
            lane_in[i] = '0;
         end
      end else if (cmd.accept && !err) begin
         img_cnt_in = SIZE_W'(img_cnt_ff + 1'b1);
         pkt_cnt_in = eop ? '0 : PAY_W'(pkt_cnt_ff + 1'b1);
         lane_in    = lane_nx;
         if (hdr) begin
            first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= SIZE_W'(1);
         img_cnt_ff <= '0;
         pkt_cnt_ff <= '0;
         pay_ff     <= '0;
         first_ff   <= 1'b1;
         for (int i = 0; i < LANES; i++) begin
            lane_ff[i] <= '0;
         end
      end else begin
         if (cmd.restart) begin
            size_ff <= csr_wdata;
         end
         img_cnt_ff <= img_cnt_in;
         pkt_cnt_ff <= pkt_cnt_in;
         first_ff   <= first_in;
         lane_ff    <= lane_in;
         if (cmd.pay_set) begin
            pay_ff <= cand_ff;
         end else if (cmd.pay_clear) begin
            pay_ff <= '0;
         end
      end
   end

   // search candidate, walked down from the largest one
   always_ff @(posedge clock) begin
      if (cmd.cand_load) begin
         cand_ff <= PAY_W'(CAND_TOP);
      end else if (cmd.cand_step) begin
         cand_ff <= PAY_W'(cand_ff - PAY_W'(PAYLOAD_ALIGN));
      end
   end

   // output slot and pending data beat
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (err) begin
            out_ff <= err_res;
         end else if (hdr) begin
            out_ff <= hdr_res;
         end else begin
            out_ff <= data_res;
         end
         pend_ff <= data_res;
      end else if (cmd.pend_to_out) begin
         out_ff <= pend_ff;
      end
   end

   assign sts.size_bad    = (size_ff == '0) ||
                            (32'(size_ff) > 32'(MAX_IMAGE_BYTES)) || (CAND_TOP == 0);
   assign sts.cand_low    = (cand_ff == PAY_W'(PAYLOAD_ALIGN));
   assign sts.two_results = !err && hdr;
   assign image_size      = size_ff;
   assign cand            = cand_ff;
   assign result          = out_ff;

endmodule

`default_nettype wire

>>> rtl/display_image_packetizer_checksum_core.sv
// Channel  Ports          Payload (low bit first)
// -------  -------------  ---------------------------------------------------------
// req      req_t*         tdata: data_byte[7:0]
// rsp      rsp_t*         tdata: out_byte, end_of_image, image_checksum, last_of_item
//                         tuser: is_header, size_error; tlast: end_of_packet
// csr      csr_we/wdata   image_size[20:0]
//
// Reset is synchronous. After reset or an image_size write the payload length is
// searched from the largest candidate down, one remainder bit per cycle: up to
// ((MAX_PAYLOAD-1)/PAYLOAD_ALIGN) candidates, limited by the bit-serial remainder
// unit; req_tready stays low meanwhile. Afterwards one byte per cycle is taken
// unless rsp stalls, which back-pressures req through a one-beat output slot. A
// packet's first byte gives two beats; req is held until the second enters the slot.
`default_nettype none

module display_image_packetizer_checksum_core #(
   parameter int PAYLOAD_ALIGN   = 16,
   parameter int MAX_PAYLOAD     = 1024,
   parameter int MAX_IMAGE_BYTES = 1048576
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // csr
   input  wire logic        csr_we,
   input  wire logic [20:0] csr_wdata,   // image_size
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [7:0] out_byte, [8] end_of_image,
                                         // [40:9] image_checksum, [41] last_of_item
   output logic [1:0]       rsp_tuser,   // [0] is_header, [1] size_error
   output logic             rsp_tlast    // end_of_packet
);
   import dipc_pkg::*;

   localparam int PAY_W = $clog2(MAX_PAYLOAD);

   dipc_cmd_type      cmd;
   dipc_sts_type      sts;
   dipc_result_type   result;
   logic              rem_start;
   logic              rem_done;
   logic              rem_zero;
   logic [SIZE_W-1:0] image_size;
   logic [PAY_W-1:0]  cand;

   dipc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rem_done   (rem_done),
      .rem_zero   (rem_zero),
      .rem_start  (rem_start),
      .sts        (sts),
      .cmd        (cmd)
   );

   dipc_datapath #(
      .PAYLOAD_ALIGN   (PAYLOAD_ALIGN),
      .MAX_PAYLOAD     (MAX_PAYLOAD),
      .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES),
      .PAY_W           (PAY_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wdata  (csr_wdata),
      .data_byte  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .image_size (image_size),
      .cand       (cand),
      .result     (result)
   );

   dipc_rem #(
      .DIV_W (PAY_W)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (image_size),
      .divisor  (cand),
      .done     (rem_done),
      .zero     (rem_zero)
   );

   // pack the response beat
   assign rsp_tdata = {6'd0, result.last_of_item, result.image_checksum,
                       result.end_of_image, result.out_byte};
   assign rsp_tuser = {result.size_error, result.is_header};
   assign rsp_tlast = result.end_of_packet;

endmodule

`default_nettype wire

>>> rtl/dipc_checker.sv
`default_nettype none

module dipc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response beat right after reset");

   // a header beat never closes the item and carries no flags
   a_header_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (!rsp_tdata[41] && !rsp_tlast && !rsp_tdata[8] && !rsp_tuser[1]))
      else $error("header beat carries data flags");

   // a size error beat is an empty, final beat
   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |->
         (rsp_tdata[7:0] == 8'd0 && rsp_tdata[41] && !rsp_tlast && !rsp_tdata[8]))
      else $error("malformed size error beat");

   // end of image also closes the packet
   a_eoi_eop: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[8]) |-> (rsp_tlast && rsp_tdata[41]))
      else $error("end of image without end of packet");

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled response beat changed");

endmodule

bind display_image_packetizer_checksum_core dipc_checker u_dipc_checker (.*);

`default_nettype wire
